/* rtl/core/nat_flow_table_unit_macros.svh */
// Assertion macros for the flow table unit.
`ifndef NAT_FLOW_TABLE_UNIT_MACROS_SVH
`define NAT_FLOW_TABLE_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define NFT_ASSERT_IMPL(label, clk_i, rst_ni, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nft check failed");

// Next-cycle implication checked outside reset.
`define NFT_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nft check failed");

`endif

/* rtl/core/nft_pkg.sv */
package nft_pkg;

  localparam int unsigned NftSlots      = 512;
  localparam logic [30:0] NftDefaultTtl = 31'd120000;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_FIND   = 3'd1;
  localparam logic [2:0] REQ_CLOSE  = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_EXPIRE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [0:0] REG_IDLE_TTL = 1'b0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] flow_port;
    logic [31:0] flow_saddr;
    logic [31:0] flow_daddr;
    logic [15:0] flow_dport;
    logic [63:0] now_ms;
  } nft_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] found_src_addr;
    logic [31:0] found_dst_addr;
    logic [15:0] found_dst_port;
    logic [63:0] found_created_ms;
    logic [9:0]  dropped;
    logic [9:0]  entry_count;
  } nft_rsp_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic        used;
    logic        closed;
    logic [63:0] last_seen;
    logic [15:0] key_port;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [63:0] created;
  } nft_entry_t;

endpackage

/* rtl/core/nat_flow_table_unit.sv */
// NAT flow table. A request beat is taken when start is high and busy low;
// busy then stays high until the result beat, which sits on out_rsp for one
// cycle marked by out_valid; the receiver cannot stall it. Every request walks
// the slot memory in order, one slot per cycle through a registered read
// port, whatever the request type: S_SCAN issues the first read and compares
// every slot, S_FIX commits an add, S_DONE forms the result, and then the
// result sits on the ports. busy is already low during the result beat, so the
// next request can be taken at the same edge as the result; a new request is
// not taken before the last one is through.
// Each slot is read, updated and written back; a pending write to the same
// slot is forwarded. After reset a clearing pass marks every slot free; busy
// is high during it. The user must write the idle TTL register over the APB
// port only while the block is idle; the block itself does not enforce this.
// Zero written gives the default of 120000 ms.
module nat_flow_table_unit #(
  parameter int unsigned TABLE_SLOTS = nft_pkg::NftSlots
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  nft_pkg::nft_req_t       in_req,
  output logic                    out_valid,
  output nft_pkg::nft_rsp_t       out_rsp,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [0:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import nft_pkg::*;

  localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_FIX, S_DONE} state_t;

  state_t        state_r;
  nft_req_t      req_r;
  logic [30:0]   ttl_r;
  logic [CW-1:0] count_r;
  logic [AW:0]   rd_idx_r;     // next address to read (wide enough for end)
  logic          rd_vld_r;     // read data valid this cycle
  logic [AW-1:0] cur_idx_r;    // address of data coming back
  logic [AW-1:0] clr_idx_r;

  nft_entry_t    mem [TABLE_SLOTS];
  nft_entry_t    rdata_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  nft_entry_t    wr_data;
  logic          fwd_vld_r;
  logic [AW-1:0] fwd_addr_r;
  nft_entry_t    fwd_data_r;

  // Scan results.
  logic          match_r, free_r, recl_r;
  logic [AW-1:0] match_idx_r, free_idx_r, recl_idx_r;
  logic [63:0]   recl_cr_r;
  logic [CW-1:0] drop_r;
  nft_rsp_t      rsp_r;
  logic          ovld_r;
  nft_rsp_t      rsp_nxt;
  logic [CW-1:0] count_nxt;

  assign pready = 1'b1;
  assign prdata = {1'b0, ttl_r};
  assign busy   = (state_r != S_IDLE);
  assign out_valid = ovld_r;
  assign out_rsp   = rsp_r;

  // Entry seen this cycle, with forwarding of last cycle's write.
  nft_entry_t cur;
  always_comb begin
    cur = rdata_r;
    if (fwd_vld_r && fwd_addr_r == cur_idx_r) cur = fwd_data_r;
  end

  logic cur_exp, port_eq, bad_port;
  always_comb begin
    cur_exp = (req_r.now_ms > cur.last_seen) &&
              ((req_r.now_ms - cur.last_seen) > {33'd0, ttl_r});
    port_eq  = cur.used && (cur.key_port == req_r.flow_port);
    bad_port = (req_r.flow_port == 16'd0);
  end

  // Write-back: in-scan updates for find/close/remove/expire, final add
  // write in S_FIX, free marking during the clearing pass.
  nft_entry_t new_ent;
  always_comb begin
    new_ent.used        = 1'b1;
    new_ent.closed      = 1'b0;
    new_ent.last_seen   = req_r.now_ms;
    new_ent.key_port    = req_r.flow_port;
    new_ent.source_addr = req_r.flow_saddr;
    new_ent.dest_addr   = req_r.flow_daddr;
    new_ent.dest_port   = req_r.flow_dport;
    new_ent.created     = req_r.now_ms;
    wr_en   = 1'b0;
    wr_addr = cur_idx_r;
    wr_data = cur;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '0;
    end else if (state_r == S_SCAN && rd_vld_r && !match_r) begin
      case (req_r.req_type)
        REQ_FIND: if (!bad_port && port_eq && !cur_exp && !cur.closed) begin
          wr_en = 1'b1;
          wr_data.last_seen = req_r.now_ms;
        end
        REQ_CLOSE: if (!bad_port && port_eq) begin
          wr_en = 1'b1;
          wr_data.closed = 1'b1;
        end
        REQ_REMOVE: if (port_eq) begin
          wr_en = 1'b1;
          wr_data = '0;
        end
        default: ;
      endcase
    end
    if (state_r == S_SCAN && rd_vld_r && req_r.req_type == REQ_EXPIRE &&
        cur.used && cur_exp) begin
      wr_en = 1'b1;
      wr_data = '0;
    end
    if (state_r == S_FIX && req_r.req_type == REQ_ADD && !bad_port &&
        (match_r || free_r || recl_r)) begin
      wr_en   = 1'b1;
      wr_addr = match_r ? match_idx_r : (free_r ? free_idx_r : recl_idx_r);
      wr_data = new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= wr_addr;
    fwd_data_r <= wr_data;
    if (!rst_n) fwd_vld_r <= 1'b0;
    else        fwd_vld_r <= wr_en;
  end

  // Result beat and entry count formed at the end of the scan. The found
  // fields only survive for a find that hit.
  always_comb begin
    rsp_nxt   = rsp_r;
    count_nxt = count_r;
    rsp_nxt.status  = ST_OK;
    rsp_nxt.dropped = '0;
    if (!(req_r.req_type == REQ_FIND && match_r && !bad_port && rsp_r.hit)) begin
      rsp_nxt.hit              = 1'b0;
      rsp_nxt.found_src_addr   = '0;
      rsp_nxt.found_dst_addr   = '0;
      rsp_nxt.found_dst_port   = '0;
      rsp_nxt.found_created_ms = '0;
    end
    case (req_r.req_type) inside
      REQ_ADD: begin
        if (bad_port) rsp_nxt.status = ST_INVALID;
        else if (!match_r && free_r) count_nxt = count_r + 1'b1;
        else if (!match_r && !recl_r) rsp_nxt.status = ST_FULL;
      end
      REQ_FIND, REQ_CLOSE: if (bad_port) rsp_nxt.status = ST_INVALID;
      REQ_REMOVE: if (match_r) count_nxt = count_r - 1'b1;
      REQ_EXPIRE: begin
        count_nxt       = count_r - drop_r;
        rsp_nxt.dropped = 10'(drop_r);
      end
      default: rsp_nxt.status = ST_INVALID;
    endcase
    rsp_nxt.entry_count = 10'(count_nxt);
  end

  // Add scan: an exact match wins; else first free; the reclaim candidate
  // only counts slots before the first free one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_idx_r <= '0;
      ttl_r    <= NftDefaultTtl;
      count_r  <= '0;
      ovld_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      ovld_r <= (state_r == S_DONE);
      if (psel && penable && pwrite && paddr == REG_IDLE_TTL)
        ttl_r <= (pwdata[30:0] == 31'd0) ? NftDefaultTtl : pwdata[30:0];
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == AW'(TABLE_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_r    <= in_req;
            rd_idx_r <= '0;
            rd_vld_r <= 1'b0;
            match_r  <= 1'b0;
            free_r   <= 1'b0;
            recl_r   <= 1'b0;
            drop_r   <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx_r < (AW+1)'(TABLE_SLOTS)) begin
            rd_idx_r  <= rd_idx_r + 1'b1;
            cur_idx_r <= rd_idx_r[AW-1:0];
            rd_vld_r  <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) begin
            if (port_eq && !match_r) begin
              match_r <= 1'b1;
              match_idx_r <= cur_idx_r;
            end
            if (!cur.used && !free_r) begin
              free_r <= 1'b1;
              free_idx_r <= cur_idx_r;
            end
            if (cur.used && !free_r && (cur_exp || cur.closed) &&
                (!recl_r || cur.created < recl_cr_r)) begin
              recl_r <= 1'b1;
              recl_idx_r <= cur_idx_r;
              recl_cr_r <= cur.created;
            end
            if (req_r.req_type == REQ_FIND && port_eq && !match_r) begin
              rsp_r.found_src_addr   <= cur.source_addr;
              rsp_r.found_dst_addr   <= cur.dest_addr;
              rsp_r.found_dst_port   <= cur.dest_port;
              rsp_r.found_created_ms <= cur.created;
              rsp_r.hit              <= !cur_exp;
            end
            if (req_r.req_type == REQ_EXPIRE && cur.used && cur_exp)
              drop_r <= drop_r + 1'b1;
            if (cur_idx_r == AW'(TABLE_SLOTS - 1)) state_r <= S_FIX;
          end
        end
        S_FIX: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          rsp_r   <= rsp_nxt;
          count_r <= count_nxt;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/nft_checker.sv */
`include "nat_flow_table_unit_macros.svh"
module nft_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input nft_pkg::nft_rsp_t out_rsp
);
  import nft_pkg::*;

  `NFT_ASSERT_NEXT(a_acc_busy, clk, rst_n, start && !busy, busy)
  `NFT_ASSERT_IMPL(a_res_busy, clk, rst_n, out_valid, !busy)
  `NFT_ASSERT_NEXT(a_one_beat, clk, rst_n, out_valid, !out_valid)
  `NFT_ASSERT_IMPL(a_hit_ok, clk, rst_n, out_valid && out_rsp.hit, out_rsp.status == ST_OK)
endmodule

bind nat_flow_table_unit nft_checker u_nft_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_rsp(out_rsp)
);

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import nft_pkg::*;

  // Request types beyond the defined set; the block must flag them invalid.
  localparam logic [2:0] REQ_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNDEF_LAST  = 3'd7;
  localparam logic [30:0] TTL_MAX        = 31'h7fff_ffff;
  // Longest stretch with no beat in either direction: clearing pass, one
  // full scan, the longest sender gap and a config write, with margin.
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 600;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  nft_req_t    in_req;
  logic        out_valid;
  nft_rsp_t    out_rsp;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  nat_flow_table_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Flow table shadow: what the block should hold after each accepted beat.
  // ---------------------------------------------------------------------------
  logic [30:0] ttl_ms;
  logic        tbl_used    [NftSlots];
  logic        tbl_closed  [NftSlots];
  logic [63:0] tbl_seen    [NftSlots];
  logic [15:0] tbl_port    [NftSlots];
  logic [31:0] tbl_saddr   [NftSlots];
  logic [31:0] tbl_daddr   [NftSlots];
  logic [15:0] tbl_dport   [NftSlots];
  logic [63:0] tbl_created [NftSlots];
  int          tbl_count;

  nft_rsp_t    rsp_queue[$];
  int          fail_count;
  logic [63:0] clock_ms;    // running wall clock for the stimulus
  int          idle_pct;
  int          new_port;    // next never-used port for the fill test

  function automatic logic idle_expired(int i, logic [63:0] now);
    return now > tbl_seen[i] && (now - tbl_seen[i]) > {33'd0, ttl_ms};
  endfunction

  function automatic int lookup_port(logic [15:0] port);
    for (int i = 0; i < NftSlots; i++)
      if (tbl_used[i] && tbl_port[i] == port) return i;
    return -1;
  endfunction

  function automatic void release_slot(int i);
    tbl_used[i]   = 1'b0;
    tbl_closed[i] = 1'b0;
    if (tbl_count > 0) tbl_count--;
  endfunction

  // Apply one request to the shadow table and return the expected result.
  function automatic nft_rsp_t apply_request(nft_req_t r);
    nft_rsp_t o;
    int       s;
    int       oldest;
    o = '0;
    o.status = ST_OK;
    case (r.req_type)
      REQ_ADD: begin
        if (r.flow_port == '0) begin
          o.status = ST_INVALID;
        end else begin
          s = lookup_port(r.flow_port);
          if (s < 0) begin
            oldest = -1;
            for (int i = 0; i < NftSlots; i++) begin
              if (!tbl_used[i]) begin
                s = i;
                tbl_count++;
                break;
              end
              // strict compare: on a creation-time tie the lower slot wins
              if ((idle_expired(i, r.now_ms) || tbl_closed[i]) &&
                  (oldest < 0 || tbl_created[i] < tbl_created[oldest]))
                oldest = i;
            end
            if (s < 0) s = oldest;
          end
          if (s < 0) begin
            o.status = ST_FULL;
          end else begin
            tbl_used[s]    = 1'b1;
            tbl_closed[s]  = 1'b0;
            tbl_seen[s]    = r.now_ms;
            tbl_port[s]    = r.flow_port;
            tbl_saddr[s]   = r.flow_saddr;
            tbl_daddr[s]   = r.flow_daddr;
            tbl_dport[s]   = r.flow_dport;
            tbl_created[s] = r.now_ms;
          end
        end
      end
      REQ_FIND: begin
        if (r.flow_port == '0) begin
          o.status = ST_INVALID;
        end else begin
          s = lookup_port(r.flow_port);
          if (s >= 0 && !idle_expired(s, r.now_ms)) begin
            o.hit              = 1'b1;
            o.found_src_addr   = tbl_saddr[s];
            o.found_dst_addr   = tbl_daddr[s];
            o.found_dst_port   = tbl_dport[s];
            o.found_created_ms = tbl_created[s];
            // a closed flow is reported but its idle time is left alone
            if (!tbl_closed[s]) tbl_seen[s] = r.now_ms;
          end
        end
      end
      REQ_CLOSE: begin
        if (r.flow_port == '0) begin
          o.status = ST_INVALID;
        end else begin
          s = lookup_port(r.flow_port);
          if (s >= 0) tbl_closed[s] = 1'b1;
        end
      end
      REQ_REMOVE: begin
        s = lookup_port(r.flow_port);
        if (s >= 0) release_slot(s);
      end
      REQ_EXPIRE: begin
        for (int i = 0; i < NftSlots; i++) begin
          if (tbl_used[i] && idle_expired(i, r.now_ms)) begin
            release_slot(i);
            o.dropped++;
          end
        end
      end
      default: o.status = ST_INVALID;
    endcase
    o.entry_count = tbl_count[9:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    nft_rsp_t want;
    if (rst_n && out_valid) begin
      if (rsp_queue.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(out_rsp.entry_count), 64'd0);
      end else begin
        want = rsp_queue.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch("status", 64'(out_rsp.status), 64'(want.status));
        if (out_rsp.hit !== want.hit)
          report_mismatch("hit", 64'(out_rsp.hit), 64'(want.hit));
        if (out_rsp.found_src_addr !== want.found_src_addr)
          report_mismatch("found_src_addr", 64'(out_rsp.found_src_addr),
                          64'(want.found_src_addr));
        if (out_rsp.found_dst_addr !== want.found_dst_addr)
          report_mismatch("found_dst_addr", 64'(out_rsp.found_dst_addr),
                          64'(want.found_dst_addr));
        if (out_rsp.found_dst_port !== want.found_dst_port)
          report_mismatch("found_dst_port", 64'(out_rsp.found_dst_port),
                          64'(want.found_dst_port));
        if (out_rsp.found_created_ms !== want.found_created_ms)
          report_mismatch("found_created_ms", out_rsp.found_created_ms,
                          want.found_created_ms);
        if (out_rsp.dropped !== want.dropped)
          report_mismatch("dropped", 64'(out_rsp.dropped), 64'(want.dropped));
        if (out_rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(out_rsp.entry_count),
                          64'(want.entry_count));
      end
    end
  end

  // Watchdog: any beat in either direction resets the count.
  int stall_cycles;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("nat_flow_table_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one request beat; returns the result the shadow table predicts.
  task automatic send_request(input nft_req_t r, output nft_rsp_t predicted);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      // mostly short gaps, now and then one that outlasts a whole scan
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    start  = 1'b1;
    in_req = r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = apply_request(r);
    rsp_queue.push_back(predicted);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic request(logic [2:0] kind, logic [15:0] port, logic [63:0] now,
                         output nft_rsp_t predicted);
    nft_req_t r;
    r.req_type   = kind;
    r.flow_port  = port;
    r.flow_saddr = $urandom;
    r.flow_daddr = $urandom;
    r.flow_dport = 16'($urandom);
    r.now_ms     = now;
    send_request(r, predicted);
  endtask

  // Every request yields a result, so an empty queue means the block is idle.
  task automatic wait_drained();
    while (rsp_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ttl(logic [31:0] value);
    wait_drained();
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = REG_IDLE_TTL;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    ttl_ms = (value[30:0] == '0) ? NftDefaultTtl : value[30:0];
  endtask

  // Port mostly from a small pool so flows collide; sometimes any value.
  function automatic logic [15:0] pick_port();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)  return '0;
    if (roll < 18) return 16'($urandom);
    return 16'($urandom_range(1, 40));
  endfunction

  task automatic random_beats(int count, int max_step);
    nft_rsp_t   dummy;
    int         roll;
    logic [2:0] kind;
    logic [63:0] now;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 38)      kind = REQ_ADD;
      else if (roll < 68) kind = REQ_FIND;
      else if (roll < 78) kind = REQ_CLOSE;
      else if (roll < 90) kind = REQ_REMOVE;
      else if (roll < 97) kind = REQ_EXPIRE;
      else                kind = 3'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
      clock_ms += 64'($urandom_range(0, max_step));
      now = clock_ms;
      // stray timestamps: arbitrary 64-bit values and clocks that run back
      roll = $urandom_range(0, 99);
      if (roll < 3)      now = {$urandom, $urandom};
      else if (roll < 6) now = clock_ms - 64'($urandom_range(0, 4 * max_step));
      request(kind, pick_port(), now, dummy);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    nft_rsp_t   p;
    nft_req_t   r;
    logic [2:0] kind;
    request(REQ_ADD, '0, 64'd1000, p);
    request(REQ_FIND, '0, 64'd1000, p);
    request(REQ_CLOSE, '0, 64'd1000, p);
    request(REQ_REMOVE, '0, 64'd1000, p);
    for (kind = REQ_UNDEF_FIRST; kind != REQ_UNDEF_LAST; kind++)
      request(kind, 16'd7, 64'd1000, p);
    request(REQ_UNDEF_LAST, 16'd7, 64'd1000, p);
    // all-ones flow, added at the top of the clock range
    r = '1;
    r.req_type = REQ_ADD;
    send_request(r, p);
    r = '0;
    r.req_type  = REQ_ADD;
    r.flow_port = 16'd1;
    r.now_ms    = 64'd1000;
    send_request(r, p);
    request(REQ_FIND, 16'd1, 64'd1500, p);
    request(REQ_FIND, 16'd2, 64'd1500, p);
    request(REQ_ADD, 16'd1, 64'd2000, p);        // replace keeps the count
    request(REQ_ADD, 16'd2, 64'd2000, p);
    request(REQ_CLOSE, 16'd1, 64'd3000, p);
    request(REQ_FIND, 16'd1, 64'd100000, p);     // closed, still fresh: no refresh
    request(REQ_FIND, 16'd1, 64'd122001, p);     // idle past the TTL: miss
    request(REQ_FIND, 16'hffff, 64'd5, p);       // clock behind last seen
    request(REQ_CLOSE, 16'd9, 64'd3000, p);
    request(REQ_REMOVE, 16'd9, 64'd3000, p);
    request(REQ_EXPIRE, '0, 64'd200000, p);
    request(REQ_REMOVE, 16'hffff, 64'd0, p);
    clock_ms = 64'd200000;
  endtask

  // Fill every slot with live flows, hit the full case, then reclaim.
  task automatic test_fill_and_reclaim();
    nft_rsp_t p;
    int       adds;
    int       fulls;
    logic [15:0] first_port;
    // sweep nearly everything out at the top of the clock range
    write_ttl(32'd1);
    request(REQ_EXPIRE, '0, '1, p);
    write_ttl({1'b0, TTL_MAX});
    first_port = new_port[15:0];
    adds  = 0;
    fulls = 0;
    while (fulls < 3 && adds < 600) begin
      // several adds share a timestamp so reclaim sees creation-time ties
      if (adds % 8 == 0) clock_ms += 1;
      request(REQ_ADD, new_port[15:0], clock_ms, p);
      new_port++;
      adds++;
      if (p.status == ST_FULL) fulls++;
    end
    // two closed flows of the same age: the lower slot goes first
    request(REQ_CLOSE, first_port + 16'd3, clock_ms, p);
    request(REQ_CLOSE, first_port + 16'd1, clock_ms, p);
    request(REQ_ADD, new_port[15:0], clock_ms, p);
    new_port++;
    request(REQ_ADD, new_port[15:0], clock_ms, p);
    new_port++;
    request(REQ_ADD, new_port[15:0], clock_ms, p);
    new_port++;
    // age the table, keep a few flows alive, then reclaim expired ones
    write_ttl(32'd1000);
    clock_ms += 600;
    for (int i = 0; i < 6; i++)
      request(REQ_FIND, first_port + 16'(8 * i), clock_ms, p);
    clock_ms += 700;
    for (int i = 0; i < 4; i++) begin
      request(REQ_ADD, new_port[15:0], clock_ms, p);
      new_port++;
    end
    request(REQ_EXPIRE, '0, clock_ms, p);
    random_beats(20, 300);
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    fail_count  = 0;
    ttl_ms      = NftDefaultTtl;
    tbl_count   = 0;
    clock_ms    = '0;
    new_port    = 1000;
    for (int i = 0; i < NftSlots; i++) begin
      tbl_used[i]   = 1'b0;
      tbl_closed[i] = 1'b0;
    end
    idle_pct = 27;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    write_ttl(32'd0);              // zero falls back to the default
    random_beats(150, 20000);
    write_ttl(32'd1);              // everything goes stale almost at once
    random_beats(40, 3);
    write_ttl(32'hffff_ffff);      // top bit ignored, longest TTL
    random_beats(100, 1000000);

    idle_pct = 58;
    test_fill_and_reclaim();

    idle_pct = 0;
    write_ttl($urandom_range(500, 5000));
    random_beats(200, 400);
    write_ttl(32'h5555_5555);
    random_beats(80, 1 << 30);

    while (rsp_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("nat_flow_table_unit test passed");
    end else begin
      $display("nat_flow_table_unit test failed");
    end
    $finish;
  end

endmodule

/* nat_flow_table_unit.f */
+incdir+rtl/core
rtl/core/nft_pkg.sv
rtl/core/nat_flow_table_unit.sv
rtl/core/nft_checker.sv
dv/tb.sv
